// ===== design/lbs_pkg.sv =====
// Shared widths, codes and types of the letterbox bilinear scaler.
package lbs_pkg;

  localparam int DIM_W    = 10;  // source dimension registers
  localparam int DST_W    = 11;  // destination dimension registers
  localparam int COORD_W  = 10;  // destination row / column
  localparam int CH_W     = 2;
  localparam int STEP_W   = 26;  // Q16 source step
  localparam int FRAC_W   = 16;
  localparam int PTR_W    = 20;  // load pointer, wraps at 2^20
  localparam int VAL_W    = 16;
  localparam int DIV_W    = 26;  // numerator width of the geometry divider
  localparam int POS_W    = COORD_W + STEP_W;
  localparam int RA_W     = 23;  // raw store address before sizing
  localparam int Q_DEPTH  = 2;

  localparam int DEF_MAX_SRC_WIDTH  = 512;
  localparam int DEF_MAX_SRC_HEIGHT = 512;
  localparam int DEF_MAX_DST_SIZE   = 1024;
  localparam int DEF_CHANNELS       = 3;
  localparam int RESET_DIM          = 416;

  localparam logic [VAL_W-1:0]  BORDER_VAL = 16'd16384;
  localparam logic [FRAC_W:0]   ONE_Q16    = 17'h10000;
  localparam logic [41:0]       ROUND_ADD  = 42'h0000_FF_0000;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic               busy;
    logic [DIM_W-1:0]   iw;
    logic [DIM_W-1:0]   ih;
    logic [DST_W-1:0]   dw;
    logic [DST_W-1:0]   dh;
    logic [DST_W-1:0]   nw;
    logic [DST_W-1:0]   nh;
    logic [COORD_W-1:0] off_x;
    logic [COORD_W-1:0] off_y;
    logic [STEP_W-1:0]  step_x;
    logic [STEP_W-1:0]  step_y;
  } geo_t;

  typedef struct packed {
    logic               pull;
    logic               border;
    logic               last;
    logic               c_end;
    logic               r_end;
    logic [7:0]         data;
    logic [PTR_W-1:0]   addr;
    logic [CH_W-1:0]    chan;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] sc;
    logic [COORD_W-1:0] sr;
  } ent_t;

endpackage

// ===== design/lbs_geom.sv =====
// Configuration registers and the iterative geometry / step divider.
module lbs_geom #(
  parameter int MAX_SRC_WIDTH  = lbs_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = lbs_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int MAX_DST_SIZE   = lbs_pkg::DEF_MAX_DST_SIZE
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [lbs_pkg::DST_W-1:0] cfg_data_i,
  output lbs_pkg::geo_t            geo_o
);

  typedef enum logic [3:0] {
    G_IDLE = 4'b0001,
    G_CMP  = 4'b0010,
    G_LOAD = 4'b0100,
    G_DIV  = 4'b1000
  } geo_state_e;

  typedef enum logic [1:0] {
    JOB_SCALE = 2'd0,
    JOB_SX    = 2'd1,
    JOB_SY    = 2'd2
  } job_e;

  localparam int CW = $clog2(lbs_pkg::DIV_W);

  geo_state_e state_q, state_d;
  job_e       job_q;
  logic [lbs_pkg::DIM_W-1:0]  iw_q, ih_q;
  logic [lbs_pkg::DST_W-1:0]  dw_q, dh_q, nw_q, nh_q;
  logic [lbs_pkg::STEP_W-1:0] step_x_q, step_y_q;
  logic                       wide_q;
  logic [lbs_pkg::DIV_W-1:0]  num_q, quot_q;
  logic [lbs_pkg::DST_W-1:0]  den_q, rem_q;
  logic [CW-1:0]              cnt_q;

  logic [lbs_pkg::DIM_W-1:0]  src_v;
  logic [lbs_pkg::DST_W-1:0]  dst_v;
  logic [20:0]                prod_a, prod_b;
  logic [lbs_pkg::DST_W:0]    trial, diff;
  logic                       qbit;
  logic [lbs_pkg::DIV_W-1:0]  quot_n;

  assign src_v  = cfg_data_i[lbs_pkg::DIM_W-1:0];
  assign dst_v  = cfg_data_i;
  assign prod_a = 21'(dw_q) * 21'(ih_q);
  assign prod_b = 21'(dh_q) * 21'(iw_q);
  assign trial  = {rem_q, num_q[lbs_pkg::DIV_W-1]};
  assign diff   = trial - {1'b0, den_q};
  assign qbit   = !diff[lbs_pkg::DST_W];
  assign quot_n = {quot_q[lbs_pkg::DIV_W-2:0], qbit};

  always_comb begin
    state_d = state_q;
    case (state_q)
      G_IDLE: state_d = G_IDLE;
      G_CMP:  state_d = G_DIV;
      G_LOAD: begin
        if (job_q == JOB_SX && nw_q > 11'd1) state_d = G_DIV;
        else if (job_q == JOB_SY && nh_q > 11'd1) state_d = G_DIV;
        else if (job_q == JOB_SY) state_d = G_IDLE;
      end
      G_DIV: begin
        if (cnt_q == CW'(lbs_pkg::DIV_W - 1)) begin
          state_d = (job_q == JOB_SY) ? G_IDLE : G_LOAD;
        end
      end
      default: state_d = G_IDLE;
    endcase
    if (cfg_we_i) state_d = G_CMP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= G_CMP;
      job_q    <= JOB_SCALE;
      iw_q     <= lbs_pkg::DIM_W'(lbs_pkg::RESET_DIM);
      ih_q     <= lbs_pkg::DIM_W'(lbs_pkg::RESET_DIM);
      dw_q     <= lbs_pkg::DST_W'(lbs_pkg::RESET_DIM);
      dh_q     <= lbs_pkg::DST_W'(lbs_pkg::RESET_DIM);
      nw_q     <= '0;
      nh_q     <= '0;
      step_x_q <= '0;
      step_y_q <= '0;
      wide_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lbs_pkg::REG_SRC_WIDTH: begin
            if (src_v == '0) iw_q <= 10'd1;
            else if (13'(src_v) > 13'(MAX_SRC_WIDTH)) iw_q <= 10'(MAX_SRC_WIDTH);
            else iw_q <= src_v;
          end
          lbs_pkg::REG_SRC_HEIGHT: begin
            if (src_v == '0) ih_q <= 10'd1;
            else if (13'(src_v) > 13'(MAX_SRC_HEIGHT)) ih_q <= 10'(MAX_SRC_HEIGHT);
            else ih_q <= src_v;
          end
          lbs_pkg::REG_DST_WIDTH: begin
            if (dst_v == '0) dw_q <= 11'd1;
            else if (13'(dst_v) > 13'(MAX_DST_SIZE)) dw_q <= 11'(MAX_DST_SIZE);
            else dw_q <= dst_v;
          end
          lbs_pkg::REG_DST_HEIGHT: begin
            if (dst_v == '0) dh_q <= 11'd1;
            else if (13'(dst_v) > 13'(MAX_DST_SIZE)) dh_q <= 11'(MAX_DST_SIZE);
            else dh_q <= dst_v;
          end
          default: iw_q <= iw_q;
        endcase
      end else begin
        case (state_q)
          G_CMP: begin
            job_q <= JOB_SCALE;
            cnt_q <= '0;
            if (prod_a < prod_b) begin
              wide_q <= 1'b1;
              nw_q   <= dw_q;
            end else begin
              wide_q <= 1'b0;
              nh_q   <= dh_q;
            end
          end
          G_LOAD: begin
            cnt_q <= '0;
            if (job_q == JOB_SX && !(nw_q > 11'd1)) begin
              step_x_q <= '0;
              job_q    <= JOB_SY;
            end else if (job_q == JOB_SY && !(nh_q > 11'd1)) begin
              step_y_q <= '0;
            end
          end
          G_DIV: begin
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == CW'(lbs_pkg::DIV_W - 1)) begin
              case (job_q)
                JOB_SCALE: begin
                  if (wide_q) nh_q <= quot_n[lbs_pkg::DST_W-1:0];
                  else nw_q <= quot_n[lbs_pkg::DST_W-1:0];
                  job_q <= JOB_SX;
                end
                JOB_SX: begin
                  step_x_q <= quot_n;
                  job_q    <= JOB_SY;
                end
                JOB_SY:  step_y_q <= quot_n;
                default: job_q <= JOB_SCALE;
              endcase
            end
          end
          default: cnt_q <= cnt_q;
        endcase
      end
    end
  end

  // Divider operands: load on entry, shift one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    case (state_q)
      G_CMP: begin
        rem_q  <= '0;
        quot_q <= '0;
        num_q  <= (prod_a < prod_b) ? lbs_pkg::DIV_W'(21'(ih_q) * 21'(dw_q))
                                    : lbs_pkg::DIV_W'(21'(iw_q) * 21'(dh_q));
        den_q  <= (prod_a < prod_b) ? 11'(iw_q) : 11'(ih_q);
      end
      G_LOAD: begin
        rem_q  <= '0;
        quot_q <= '0;
        if (job_q == JOB_SX) begin
          num_q <= {lbs_pkg::DIV_W'(iw_q - 1'b1)} << lbs_pkg::FRAC_W;
          den_q <= nw_q - 1'b1;
        end else begin
          num_q <= {lbs_pkg::DIV_W'(ih_q - 1'b1)} << lbs_pkg::FRAC_W;
          den_q <= nh_q - 1'b1;
        end
      end
      G_DIV: begin
        num_q  <= {num_q[lbs_pkg::DIV_W-2:0], 1'b0};
        quot_q <= quot_n;
        rem_q  <= qbit ? diff[lbs_pkg::DST_W-1:0] : trial[lbs_pkg::DST_W-1:0];
      end
      default: num_q <= num_q;
    endcase
  end

  assign geo_o.busy   = (state_q != G_IDLE);
  assign geo_o.iw     = iw_q;
  assign geo_o.ih     = ih_q;
  assign geo_o.dw     = dw_q;
  assign geo_o.dh     = dh_q;
  assign geo_o.nw     = nw_q;
  assign geo_o.nh     = nh_q;
  assign geo_o.off_x  = lbs_pkg::COORD_W'((dw_q - nw_q) >> 1);
  assign geo_o.off_y  = lbs_pkg::COORD_W'((dh_q - nh_q) >> 1);
  assign geo_o.step_x = step_x_q;
  assign geo_o.step_y = step_y_q;

endmodule

// ===== design/lbs_front.sv =====
// Front end: accepts beats, walks the destination, classifies each beat.
module lbs_front #(
  parameter int CHANNELS    = lbs_pkg::DEF_CHANNELS,
  parameter int STORE_DEPTH = 786432
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  lbs_pkg::geo_t        geo_i,
  input  logic                 accept_i,
  input  logic                 op_i,
  input  logic [7:0]           data_byte_i,
  output logic                 q_push_o,
  output lbs_pkg::ent_t        q_data_o
);

  logic [lbs_pkg::PTR_W-1:0]   ptr_q;
  logic [lbs_pkg::CH_W-1:0]    chan_q;
  logic [lbs_pkg::COORD_W-1:0] row_q, col_q;

  logic       col_end, row_end, chan_end, in_store;
  logic [11:0] x_hi, y_hi;
  logic [lbs_pkg::COORD_W-1:0] sc, sr;

  assign col_end  = !(({1'b0, col_q} + 11'd1) < geo_i.dw);
  assign row_end  = !(({1'b0, row_q} + 11'd1) < geo_i.dh);
  assign chan_end = !((32'(chan_q) + 32'd1) < 32'(CHANNELS));
  assign in_store = (32'(ptr_q) < 32'(STORE_DEPTH));
  assign x_hi     = 12'(geo_i.off_x) + 12'(geo_i.nw);
  assign y_hi     = 12'(geo_i.off_y) + 12'(geo_i.nh);
  assign sc       = col_q - geo_i.off_x;
  assign sr       = row_q - geo_i.off_y;

  always_comb begin
    q_data_o.pull   = op_i;
    q_data_o.border = (col_q < geo_i.off_x) || !(12'(col_q) < x_hi) ||
                      (row_q < geo_i.off_y) || !(12'(row_q) < y_hi);
    q_data_o.last   = col_end && row_end && chan_end;
    q_data_o.c_end  = ({1'b0, sc} == geo_i.nw - 11'd1);
    q_data_o.r_end  = (geo_i.nh > 11'd1) && ({1'b0, sr} == geo_i.nh - 11'd1);
    q_data_o.data   = data_byte_i;
    q_data_o.addr   = ptr_q;
    q_data_o.chan   = chan_q;
    q_data_o.row    = row_q;
    q_data_o.col    = col_q;
    q_data_o.sc     = sc;
    q_data_o.sr     = sr;
  end

  // Drop loads past the end of the store.
  assign q_push_o = accept_i && (op_i || in_store);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      chan_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
    end else if (cfg_we_i) begin
      ptr_q  <= '0;
      chan_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
    end else if (accept_i) begin
      if (!op_i) begin
        ptr_q <= ptr_q + 1'b1;
      end else if (!col_end) begin
        col_q <= col_q + 1'b1;
      end else begin
        col_q <= '0;
        if (!row_end) begin
          row_q <= row_q + 1'b1;
        end else begin
          row_q <= '0;
          if (!chan_end) begin
            chan_q <= chan_q + 1'b1;
          end else begin
            chan_q <= '0;
            ptr_q  <= '0;
          end
        end
      end
    end
  end

endmodule

// ===== design/lbs_fifo.sv =====
// Short queue between the front end and the back end.
module lbs_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lbs_pkg::ent_t data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output lbs_pkg::ent_t data_o
);

  localparam int PW = (lbs_pkg::Q_DEPTH > 1) ? $clog2(lbs_pkg::Q_DEPTH) : 1;
  localparam int NW = $clog2(lbs_pkg::Q_DEPTH + 1);

  lbs_pkg::ent_t slot_q [lbs_pkg::Q_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == NW'(lbs_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PW'(lbs_pkg::Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PW'(lbs_pkg::Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== design/lbs_back.sv =====
// Back end: source store, bilinear datapath and the result register.
module lbs_back #(
  parameter int CHANNELS    = lbs_pkg::DEF_CHANNELS,
  parameter int STORE_DEPTH = 786432
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lbs_pkg::geo_t                 geo_i,
  input  logic                          q_empty_i,
  input  lbs_pkg::ent_t                 q_data_i,
  output logic                          q_pop_o,
  input  logic                          pop,
  output logic                          empty,
  output logic [lbs_pkg::VAL_W-1:0]     pixel_value_o,
  output logic [lbs_pkg::CH_W-1:0]      channel_o,
  output logic [lbs_pkg::COORD_W-1:0]   row_o,
  output logic [lbs_pkg::COORD_W-1:0]   column_o,
  output logic                          last_o
);

  localparam int AW = $clog2(STORE_DEPTH);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_POS  = 10'b00_0000_0010,
    ST_ADDR = 10'b00_0000_0100,
    ST_RD   = 10'b00_0000_1000,
    ST_HMUL = 10'b00_0001_0000,
    ST_VMUL = 10'b00_0010_0000,
    ST_SUM  = 10'b00_0100_0000,
    ST_DIV  = 10'b00_1000_0000,
    ST_FIX  = 10'b01_0000_0000,
    ST_OUT  = 10'b10_0000_0000
  } back_state_e;

  back_state_e state_q, state_d;
  lbs_pkg::ent_t cur_q;

  logic [7:0] mem_q [STORE_DEPTH];
  logic [7:0] rdata_q;
  logic [7:0] pix_q [4];

  logic [lbs_pkg::POS_W-1:0]   sx_q, sy_q;
  logic [lbs_pkg::DIM_W-1:0]   ix_q, ix1_q;
  logic [lbs_pkg::FRAC_W-1:0]  fx_q, fy_q;
  logic [19:0]                 rb0_q, rb1_q;
  logic [2:0]                  cnt_q;
  logic [23:0]                 h0_q, h1_q, t_q;
  logic [40:0]                 va_q, vb_q;
  logic [16:0]                 q0_q;
  logic [lbs_pkg::VAL_W-1:0]   val_q;
  logic                        out_valid_q;

  logic                        out_free, mem_we;
  logic [lbs_pkg::DIM_W-1:0]   last_x, last_y, ix_c, ix1_c, iy_c, iy1_c;
  logic [19:0]                 sx_int, sy_int;
  logic [lbs_pkg::FRAC_W-1:0]  fx_c, fy_c;
  logic                        x_pin, y_pin;
  logic [19:0]                 rb_sel;
  logic [lbs_pkg::DIM_W-1:0]   x_sel;
  logic [20:0]                 rsum;
  logic [lbs_pkg::RA_W-1:0]    raddr;
  logic [lbs_pkg::CH_W-1:0]    src_ch;
  logic [lbs_pkg::FRAC_W:0]    wx0, wy0;
  logic [24:0]                 hs0, hs1;
  logic [41:0]                 vsum;
  logic [32:0]                 recip;
  logic [24:0]                 q0x255, rem;

  assign out_free = !out_valid_q || pop;
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;
  assign mem_we   = q_pop_o && !q_data_i.pull;

  // Sample positions; last column, and last row if nh > 1, pin to edge pixels.
  assign last_x = geo_i.iw - 1'b1;
  assign last_y = geo_i.ih - 1'b1;
  assign sx_int = sx_q[lbs_pkg::POS_W-1:lbs_pkg::FRAC_W];
  assign sy_int = sy_q[lbs_pkg::POS_W-1:lbs_pkg::FRAC_W];
  assign x_pin  = cur_q.c_end || (geo_i.iw == 10'd1);
  assign y_pin  = cur_q.r_end;
  assign ix_c   = x_pin ? last_x : (sx_int > 20'(last_x)) ? last_x : sx_int[9:0];
  assign iy_c   = y_pin ? last_y : (sy_int > 20'(last_y)) ? last_y : sy_int[9:0];
  assign fx_c   = x_pin ? '0 : sx_q[lbs_pkg::FRAC_W-1:0];
  assign fy_c   = y_pin ? '0 : sy_q[lbs_pkg::FRAC_W-1:0];
  assign ix1_c  = (ix_c == last_x) ? last_x : ix_c + 1'b1;
  assign iy1_c  = (iy_c == last_y) ? last_y : iy_c + 1'b1;

  assign src_ch = lbs_pkg::CH_W'(CHANNELS - 1) - cur_q.chan;
  assign rb_sel = cnt_q[1] ? rb1_q : rb0_q;
  assign x_sel  = cnt_q[0] ? ix1_q : ix_q;
  assign rsum   = {1'b0, rb_sel} + 21'(x_sel);
  assign raddr  = (lbs_pkg::RA_W'(rsum) << 1) + lbs_pkg::RA_W'(rsum) +
                  lbs_pkg::RA_W'(src_ch);

  assign wx0    = lbs_pkg::ONE_Q16 - {1'b0, fx_q};
  assign wy0    = lbs_pkg::ONE_Q16 - {1'b0, fy_q};
  assign hs0    = 25'(wx0) * 25'(pix_q[0]) + 25'(fx_q) * 25'(pix_q[1]);
  assign hs1    = 25'(wx0) * 25'(pix_q[2]) + 25'(fx_q) * 25'(pix_q[3]);
  assign vsum   = 42'(va_q) + 42'(vb_q) + lbs_pkg::ROUND_ADD;
  assign recip  = 33'(t_q) * 33'd257;
  assign q0x255 = {q0_q, 8'b0} - 25'(q0_q);
  assign rem    = 25'(t_q) - q0x255;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[AW'(q_data_i.addr)] <= q_data_i.data;
    rdata_q <= mem_q[AW'(raddr)];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_pop_o && q_data_i.pull) state_d = q_data_i.border ? ST_OUT : ST_POS;
      end
      ST_POS:  state_d = ST_ADDR;
      ST_ADDR: state_d = ST_RD;
      ST_RD:   if (cnt_q == 3'd4) state_d = ST_HMUL;
      ST_HMUL: state_d = ST_VMUL;
      ST_VMUL: state_d = ST_SUM;
      ST_SUM:  state_d = ST_DIV;
      ST_DIV:  state_d = ST_FIX;
      ST_FIX:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ADDR) cnt_q <= '0;
      else if (state_q == ST_RD) cnt_q <= cnt_q + 1'b1;
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (pop) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (q_pop_o) begin
          cur_q <= q_data_i;
          val_q <= lbs_pkg::BORDER_VAL;
        end
      end
      ST_POS: begin
        sx_q <= lbs_pkg::POS_W'(cur_q.sc) * lbs_pkg::POS_W'(geo_i.step_x);
        sy_q <= lbs_pkg::POS_W'(cur_q.sr) * lbs_pkg::POS_W'(geo_i.step_y);
      end
      ST_ADDR: begin
        ix_q  <= ix_c;
        ix1_q <= ix1_c;
        fx_q  <= fx_c;
        fy_q  <= fy_c;
        rb0_q <= 20'(iy_c) * 20'(geo_i.iw);
        rb1_q <= 20'(iy1_c) * 20'(geo_i.iw);
      end
      ST_RD: begin
        // Read data is registered, so pixel n is captured while cnt_q is n + 1.
        if (cnt_q != 3'd0) pix_q[2'(cnt_q - 3'd1)] <= rdata_q;
      end
      ST_HMUL: begin
        h0_q <= hs0[23:0];
        h1_q <= hs1[23:0];
      end
      ST_VMUL: begin
        va_q <= 41'(wy0) * 41'(h0_q);
        vb_q <= 41'(fy_q) * 41'(h1_q);
      end
      ST_SUM: t_q  <= vsum[40:17];
      ST_DIV: q0_q <= recip[32:16];
      ST_FIX: val_q <= lbs_pkg::VAL_W'(q0_q + 17'(rem >= 25'd255));
      ST_OUT: begin
        if (out_free) begin
          pixel_value_o <= val_q;
          channel_o     <= cur_q.chan;
          row_o         <= cur_q.row;
          column_o      <= cur_q.col;
          last_o        <= cur_q.last;
        end
      end
      default: val_q <= val_q;
    endcase
  end

  assign empty = !out_valid_q;

endmodule

// ===== design/letterbox_bilinear_scaler.sv =====
// Top level of the letterbox bilinear scaler.
//
//  port group      direction  handshake        payload
//  input queue     in         push / full      op_i, data_byte_i
//  result queue    out        pop / empty      pixel_value_o, channel_o, row_o,
//                                              column_o, last_o
//  configuration   in         cfg_we_i         cfg_idx_i, cfg_data_i
//
// A load is written to the source store as it leaves the queue. A pull inside
// the scaled picture steps through the back-end sequencer: four reads through
// the one read port of the source store, then two multiply stages and a divide
// by 255. A border pull goes straight to the output. After reset and after each
// register write the geometry divider runs with full held high. The result
// register lets the back end finish the next value while one waits on pop.
module letterbox_bilinear_scaler #(
  parameter int MAX_SRC_WIDTH  = lbs_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = lbs_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int MAX_DST_SIZE   = lbs_pkg::DEF_MAX_DST_SIZE,
  parameter int CHANNELS       = lbs_pkg::DEF_CHANNELS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [lbs_pkg::DST_W-1:0]     cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic                          op_i,
  input  logic [7:0]                    data_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [lbs_pkg::VAL_W-1:0]     pixel_value_o,
  output logic [lbs_pkg::CH_W-1:0]      channel_o,
  output logic [lbs_pkg::COORD_W-1:0]   row_o,
  output logic [lbs_pkg::COORD_W-1:0]   column_o,
  output logic                          last_o
);

  localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT * CHANNELS;

  lbs_pkg::geo_t geo;
  lbs_pkg::ent_t q_in, q_out;
  logic          q_push, q_pop, q_full, q_empty, accept;

  assign full   = q_full || geo.busy;
  assign accept = push && !full;

  lbs_geom #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
    .MAX_DST_SIZE  (MAX_DST_SIZE)
  ) u_geom (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .geo_o     (geo)
  );

  lbs_front #(
    .CHANNELS   (CHANNELS),
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .geo_i      (geo),
    .accept_i   (accept),
    .op_i       (op_i),
    .data_byte_i(data_byte_i),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  lbs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .pop_i  (q_pop),
    .full_o (q_full),
    .empty_o(q_empty),
    .data_o (q_out)
  );

  lbs_back #(
    .CHANNELS   (CHANNELS),
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geo_i        (geo),
    .q_empty_i    (q_empty),
    .q_data_i     (q_out),
    .q_pop_o      (q_pop),
    .pop          (pop),
    .empty        (empty),
    .pixel_value_o(pixel_value_o),
    .channel_o    (channel_o),
    .row_o        (row_o),
    .column_o     (column_o),
    .last_o       (last_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("queue push while full");

  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    geo.busy |-> full) else $error("input open during geometry recompute");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> pixel_value_o <= 16'd32768) else $error("value above 1.0");

  a_last_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_o) |-> channel_o == lbs_pkg::CH_W'(CHANNELS - 1))
    else $error("last marked outside the final plane");

endmodule

// ===== bench/letterbox_bilinear_scaler_test.sv =====
// Testbench for the letterbox bilinear scaler: directed and random load/pull traffic.
`timescale 1ns / 1ps
module letterbox_bilinear_scaler_test;

  localparam int STORE_SIZE = 512 * 512 * 3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 24;

  typedef struct {
    logic [lbs_pkg::VAL_W-1:0]   val;
    logic [lbs_pkg::CH_W-1:0]    ch;
    logic [lbs_pkg::COORD_W-1:0] row;
    logic [lbs_pkg::COORD_W-1:0] col;
    logic                        last;
  } pix_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = lbs_pkg::REG_SRC_WIDTH;
  logic [lbs_pkg::DST_W-1:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  logic op_i = 1'b0;
  logic [7:0] data_byte_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [lbs_pkg::VAL_W-1:0] pixel_value_o;
  logic [lbs_pkg::CH_W-1:0] channel_o;
  logic [lbs_pkg::COORD_W-1:0] row_o, column_o;
  logic last_o;

  letterbox_bilinear_scaler u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push, .full, .op_i, .data_byte_i,
    .empty, .pop, .pixel_value_o, .channel_o, .row_o, .column_o, .last_o
  );

  // Shadow of the block state
  byte unsigned src_img[STORE_SIZE];
  int unsigned load_ptr, walk_ch, walk_row, walk_col;
  longint unsigned src_w, src_h, dst_w, dst_h, fit_w, fit_h, pad_x, pad_y, step_x, step_y;
  pix_beat_t pix_q[$];
  int unsigned mism_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit idle_en = 1'b1;
  int unsigned pop_hold = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void refit_geometry();
    if (dst_w * src_h < dst_h * src_w) begin
      fit_w = dst_w;
      fit_h = (src_h * dst_w) / src_w;
    end else begin
      fit_h = dst_h;
      fit_w = (src_w * dst_h) / src_h;
    end
    pad_x = (dst_w - fit_w) / 2;
    pad_y = (dst_h - fit_h) / 2;
    step_x = fit_w > 1 ? ((src_w - 1) << 16) / (fit_w - 1) : 0;
    step_y = fit_h > 1 ? ((src_h - 1) << 16) / (fit_h - 1) : 0;
    load_ptr = 0;
    walk_ch = 0;
    walk_row = 0;
    walk_col = 0;
  endfunction

  function automatic longint unsigned src_px(longint unsigned x, longint unsigned y,
                                             longint unsigned ch);
    longint unsigned a;
    a = (y * src_w + x) * 3 + ch;
    return a >= STORE_SIZE ? 0 : src_img[a];
  endfunction

  function automatic longint unsigned blend_row(longint unsigned c, longint unsigned y,
                                                longint unsigned ch);
    longint unsigned sx, ix, fx, acc, lastx;
    lastx = src_w - 1;
    if (c == fit_w - 1 || src_w == 1) return src_px(lastx, y, ch) << 16;
    sx = c * step_x;
    ix = sx >> 16;
    fx = sx & 64'hFFFF;
    if (ix > lastx) ix = lastx;
    acc = (65536 - fx) * src_px(ix, y, ch);
    if (fx != 0) acc += fx * src_px(ix + 1 > lastx ? lastx : ix + 1, y, ch);
    return acc;
  endfunction

  function automatic int unsigned scaled_value(longint unsigned k, longint unsigned row,
                                               longint unsigned col);
    longint unsigned c, r, ch, lasty, sy, iy, fy, acc;
    if (col < pad_x || col >= pad_x + fit_w || row < pad_y || row >= pad_y + fit_h)
      return 16384;
    c = col - pad_x;
    r = row - pad_y;
    ch = 2 - k;
    lasty = src_h - 1;
    if (fit_h > 1 && r == fit_h - 1) begin
      acc = blend_row(c, lasty, ch) << 16;
    end else begin
      sy = r * step_y;
      iy = sy >> 16;
      fy = sy & 64'hFFFF;
      if (iy > lasty) iy = lasty;
      acc = (65536 - fy) * blend_row(c, iy, ch);
      if (fy != 0) acc += fy * blend_row(c, iy + 1 > lasty ? lasty : iy + 1, ch);
    end
    return int'((acc + (64'd255 << 16)) / (64'd255 << 17));
  endfunction

  function automatic void predict_beat(bit op, byte unsigned d);
    pix_beat_t e;
    if (!op) begin
      if (load_ptr < STORE_SIZE) src_img[load_ptr] = d;
      load_ptr = (load_ptr + 1) & 32'hFFFFF;
      return;
    end
    e.val = lbs_pkg::VAL_W'(scaled_value(walk_ch, walk_row, walk_col));
    e.ch = lbs_pkg::CH_W'(walk_ch);
    e.row = lbs_pkg::COORD_W'(walk_row);
    e.col = lbs_pkg::COORD_W'(walk_col);
    e.last = 1'b0;
    if (walk_col + 1 < dst_w) begin
      walk_col++;
    end else begin
      walk_col = 0;
      if (walk_row + 1 < dst_h) begin
        walk_row++;
      end else begin
        walk_row = 0;
        if (walk_ch + 1 < 3) begin
          walk_ch++;
        end else begin
          walk_ch = 0;
          load_ptr = 0;
          e.last = 1'b1;
        end
      end
    end
    pix_q.push_back(e);
  endfunction

  // Result side: check each beat, stall pop in bursts
  always @(posedge clk_i) begin
    pix_beat_t e;
    if (rst_ni && pop && !empty) begin
      if (pix_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10) $display("unexpected beat: val %0d ch %0d row %0d col %0d",
                                     pixel_value_o, channel_o, row_o, column_o);
      end else begin
        e = pix_q.pop_front();
        if (pixel_value_o !== e.val || channel_o !== e.ch || row_o !== e.row ||
            column_o !== e.col || last_o !== e.last) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display({"mismatch: exp val %0d ch %0d row %0d col %0d last %0d, ",
                      "got %0d %0d %0d %0d %0d"},
                     e.val, e.ch, e.row, e.col, e.last,
                     pixel_value_o, channel_o, row_o, column_o, last_o);
        end
      end
    end
    if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      pop_hold <= $urandom_range(0, 11);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic send_item(bit op, byte unsigned d);
    if (idle_en && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    push <= 1'b1;
    op_i <= op;
    data_byte_i <= d;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_beat(op, d);
  endtask

  // Hold until every result is back and the back end has drained
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pix_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_regs(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh);
    logic [lbs_pkg::DST_W-1:0] v[4];
    v[0] = lbs_pkg::DST_W'(sw);
    v[1] = lbs_pkg::DST_W'(sh);
    v[2] = lbs_pkg::DST_W'(dw);
    v[3] = lbs_pkg::DST_W'(dh);
    settle();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= lbs_pkg::cfg_reg_e'(i);
      cfg_data_i <= v[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    src_w = v[0][lbs_pkg::DIM_W-1:0] == 0 ? 1 :
            (v[0][lbs_pkg::DIM_W-1:0] > 512 ? 512 : v[0][lbs_pkg::DIM_W-1:0]);
    src_h = v[1][lbs_pkg::DIM_W-1:0] == 0 ? 1 :
            (v[1][lbs_pkg::DIM_W-1:0] > 512 ? 512 : v[1][lbs_pkg::DIM_W-1:0]);
    dst_w = v[2] == 0 ? 1 : (v[2] > 1024 ? 1024 : v[2]);
    dst_h = v[3] == 0 ? 1 : (v[3] > 1024 ? 1024 : v[3]);
    refit_geometry();
  endtask

  // Load the whole source image, then pull with a share of stray loads mixed in
  task automatic run_image(int unsigned pulls, int unsigned stray_pct, bit edge_bytes);
    int unsigned n;
    byte unsigned d;
    n = 32'(src_w * src_h * 3);
    for (int unsigned i = 0; i < n; i++) begin
      d = edge_bytes ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
      send_item(1'b0, d);
    end
    for (int unsigned i = 0; i < pulls; i++) begin
      if ($urandom_range(0, 99) < stray_pct) send_item(1'b0, 8'($urandom_range(0, 255)));
      send_item(1'b1, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_directed();
    write_regs(2, 2, 3, 2);
    run_image(8, 0, 1'b1);
  endtask

  task automatic test_register_clamp();
    write_regs(0, 0, 0, 0);
    run_image(3, 0, 1'b0);
    // Columns left of the scaled area are border, so no source is needed
    write_regs(1023, 1, 2047, 1);
    for (int i = 0; i < 20; i++) send_item(1'b1, 8'h00);
  endtask

  task automatic test_tall_source();
    write_regs(1, 12, 1, 40);
    run_image(120, 2, 1'b0);
  endtask

  task automatic test_zero_scale();
    write_regs(512, 1, 1, 4);
    for (int i = 0; i < 14; i++) send_item(1'b1, 8'h00);
  endtask

  task automatic test_pause();
    write_regs(3, 2, 5, 5);
    run_image(30, 10, 1'b0);
    settle();
    run_image(50, 10, 1'b0);
  endtask

  task automatic test_random(int unsigned budget);
    int unsigned sent, pulls;
    while (sent < budget) begin
      write_regs($urandom_range(1, 8), $urandom_range(1, 8),
                 $urandom_range(1, 12), $urandom_range(1, 12));
      pulls = $urandom_range(1, 32'(dst_w * dst_h * 3 + 20));
      sent += 32'(src_w * src_h * 3) + pulls;
      run_image(pulls, 10, 1'b0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_clamp();
    test_tall_source();
    test_zero_scale();
    test_pause();
    test_random(800);
    idle_en = 1'b0;
    test_random(150);
    settle();
    if (mism_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
